[hdl/fpve_pkg.sv]
package fpve_pkg;

	// Longest key in bytes, the '=' separator included.
	localparam int KEY_MAX = 16;
	localparam int KEY_LEN_W = 5;

	// Field separator of a record.
	localparam logic [7:0] COMMA_BYTE = 8'h2C;

	// Result queue geometry.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_KEY_LOW = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_MISSING = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] value;
		logic last;
	} result_t;

	// Results that one input byte produces, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t first;
		result_t second;
	} step_res_t;

endpackage

[hdl/field_prefix_value_extractor.sv]
// Record field lookup: takes one record byte per cycle while the result queue has room and
// returns the value of the first comma-separated field that starts with the programmed key
// (up to 16 bytes, '=' included), one value byte per word, then a value-complete word, or a
// not-found word when the record ends without a match. The sustained rate is one byte per
// clock while the queue has room; a byte is registered on entry, then any words it yields
// (at most two) are written together into a four-entry result queue and offered in order.
// The input keeps flowing while the output stalls until more than two words are waiting.
// Program the key registers (byte addresses 0, 8 and 16) only while the block is idle.
module field_prefix_value_extractor (
	input logic clk,
	input logic arst_n,
	// Configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	// Record bytes
	input logic item_valid,
	output logic item_ready,
	input logic [7:0] data_byte,
	input logic record_end,
	// Results
	output logic result_valid,
	input logic result_ready,
	output logic [1:0] result_kind,
	output logic [7:0] value_byte,
	output logic last
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [fpve_pkg::KEY_LEN_W-1:0] key_length_q;
	logic valid_s1;
	logic [7:0] data_byte_s1;
	logic record_end_s1;
	logic advance;
	logic room;
	fpve_pkg::step_res_t step_res;
	fpve_pkg::result_t head;

	assign pready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_length_q <= fpve_pkg::KEY_LEN_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:3])
				fpve_pkg::REG_KEY_LOW: key_low_q <= pwdata;
				fpve_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				fpve_pkg::REG_KEY_LENGTH: key_length_q <= pwdata[fpve_pkg::KEY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (paddr[4:3])
			fpve_pkg::REG_KEY_LOW: prdata = key_low_q;
			fpve_pkg::REG_KEY_HIGH: prdata = key_high_q;
			fpve_pkg::REG_KEY_LENGTH: prdata = 64'(key_length_q);
			default: prdata = '0;
		endcase
	end

	// Input register: a byte moves on when the queue can take its words.
	assign advance = valid_s1 && room;
	assign item_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			data_byte_s1 <= data_byte;
			record_end_s1 <= record_end;
		end
	end

	fpve_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.data_byte(data_byte_s1),
		.record_end(record_end_s1),
		.key_low(key_low_q),
		.key_high(key_high_q),
		.key_length(key_length_q),
		.res(step_res)
	);

	fpve_res_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.push_res(step_res),
		.room(room),
		.head_valid(result_valid),
		.head_ready(result_ready),
		.head(head)
	);

	assign result_kind = head.kind;
	assign value_byte = head.value;
	assign last = head.last;

endmodule

[hdl/fpve_core.sv]
module fpve_core (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [7:0] data_byte,
	input logic record_end,
	input logic [63:0] key_low,
	input logic [63:0] key_high,
	input logic [fpve_pkg::KEY_LEN_W-1:0] key_length,
	output fpve_pkg::step_res_t res
);

	typedef enum logic [1:0] {
		PH_MATCH = 2'd0,
		PH_SKIP = 2'd1,
		PH_VALUE = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	phase_t phase_q;
	phase_t phase_eff;
	phase_t phase_n;
	logic [fpve_pkg::KEY_LEN_W-1:0] kpos_q;
	logic [fpve_pkg::KEY_LEN_W-1:0] kpos_n;
	logic [fpve_pkg::KEY_LEN_W-1:0] kpos_inc;
	logic [fpve_pkg::KEY_LEN_W-1:0] len;
	logic [127:0] key_all;
	logic [7:0] key_byte;
	logic is_comma;
	fpve_pkg::result_t body_res;
	fpve_pkg::result_t end_res;
	logic body_hit;
	logic end_hit;

	// Active key length, saturated to the longest key.
	assign len = (key_length > fpve_pkg::KEY_LEN_W'(fpve_pkg::KEY_MAX)) ?
		fpve_pkg::KEY_LEN_W'(fpve_pkg::KEY_MAX) : key_length;

	// Key byte expected at the current match position.
	assign key_all = {key_high, key_low};
	assign key_byte = key_all[{kpos_q[3:0], 3'b000} +: 8];
	assign is_comma = (data_byte == fpve_pkg::COMMA_BYTE);
	assign kpos_inc = kpos_q + fpve_pkg::KEY_LEN_W'(1);

	// Next state and the results of one byte.
	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_MATCH && kpos_q >= len) begin
			phase_eff = PH_VALUE;
		end
		phase_n = phase_eff;
		kpos_n = kpos_q;
		body_hit = 1'b0;
		body_res = '{kind: fpve_pkg::KIND_BYTE, value: 8'd0, last: 1'b0};
		end_hit = 1'b0;
		end_res = '{kind: fpve_pkg::KIND_DONE, value: 8'd0, last: 1'b1};

		unique case (phase_eff)
			PH_MATCH: begin
				if (is_comma) begin
					kpos_n = '0;
				end else if (data_byte == key_byte) begin
					kpos_n = kpos_inc;
					if (kpos_inc >= len) begin
						phase_n = PH_VALUE;
					end
				end else begin
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (is_comma) begin
					phase_n = PH_MATCH;
					kpos_n = '0;
				end
			end
			PH_VALUE: begin
				body_hit = 1'b1;
				if (is_comma) begin
					body_res = '{kind: fpve_pkg::KIND_DONE, value: 8'd0, last: 1'b1};
					phase_n = PH_DONE;
				end else begin
					body_res = '{kind: fpve_pkg::KIND_BYTE, value: data_byte, last: 1'b0};
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// The end of the record closes the value or reports a miss.
		if (record_end) begin
			if (phase_n == PH_VALUE) begin
				end_hit = 1'b1;
			end else if (phase_n == PH_MATCH || phase_n == PH_SKIP) begin
				end_hit = 1'b1;
				end_res.kind = fpve_pkg::KIND_MISSING;
			end
			phase_n = PH_MATCH;
			kpos_n = '0;
		end

		res.count = {1'b0, body_hit} + {1'b0, end_hit};
		res.first = body_hit ? body_res : end_res;
		res.second = end_res;
	end

	// Parser state advances once per byte taken from the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MATCH;
			kpos_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			kpos_q <= kpos_n;
		end
	end

	a_kpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kpos_q <= fpve_pkg::KEY_LEN_W'(fpve_pkg::KEY_MAX))
		else $error("key position beyond the longest key");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> (res.first.kind == fpve_pkg::KIND_BYTE &&
			res.second.kind == fpve_pkg::KIND_DONE))
		else $error("two results must be a value byte then value complete");

	a_record_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && record_end |=> phase_q == PH_MATCH && kpos_q == '0)
		else $error("state not back at field start after a record");

endmodule

[hdl/fpve_res_queue.sv]
module fpve_res_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fpve_pkg::step_res_t push_res,
	output logic room,
	output logic head_valid,
	input logic head_ready,
	output fpve_pkg::result_t head
);

	fpve_pkg::result_t mem_q [fpve_pkg::QUEUE_DEPTH];
	logic [fpve_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fpve_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fpve_pkg::QCNT_W-1:0] count_q;
	logic [1:0] push_cnt;
	logic pop;

	assign push_cnt = push ? push_res.count : 2'd0;
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign pop = head_valid && head_ready;
	// Space for the two words one byte can produce.
	assign room = (count_q <= fpve_pkg::QCNT_W'(fpve_pkg::QUEUE_DEPTH - 2));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fpve_pkg::QPTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + fpve_pkg::QPTR_W'(pop);
			count_q <= count_q + fpve_pkg::QCNT_W'(push_cnt) - fpve_pkg::QCNT_W'(pop);
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_res.first;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + fpve_pkg::QPTR_W'(1)] <= push_res.second;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result queue pushed without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fpve_pkg::QCNT_W'(fpve_pkg::QUEUE_DEPTH))
		else $error("result queue count out of range");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !head_ready |=> head_valid && $stable(head))
		else $error("waiting result word changed before it was taken");

endmodule
